>>> rtl/core/lfdc_pkg.sv
`default_nettype none

package lfdc_pkg;

  // Field and timer widths.
  localparam int unsigned SAMPLE_BITS = 12;
  localparam int unsigned TIMER_BITS  = 16;
  localparam int unsigned CFG_IDX_BITS  = 3;
  localparam int unsigned CFG_DATA_BITS = 16;

  // Motor direction codes.
  localparam logic [1:0] DIR_STOP = 2'd0;
  localparam logic [1:0] DIR_FWD  = 2'd1;
  localparam logic [1:0] DIR_BACK = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_BITS-1:0] CFG_LINE_THRESHOLD = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_INVERT_SENSORS = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_FOLLOW_SPEED   = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_TURN_SPEED     = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MANUAL_SPEED   = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] CFG_IDLE_TIMEOUT   = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] CFG_TURN_DURATION  = 3'd6;

  // Configuration reset values.
  localparam logic [SAMPLE_BITS-1:0] RST_LINE_THRESHOLD = SAMPLE_BITS'(2000);
  localparam logic [7:0]             RST_FOLLOW_SPEED   = 8'd150;
  localparam logic [7:0]             RST_TURN_SPEED     = 8'd180;
  localparam logic [7:0]             RST_MANUAL_SPEED   = 8'd180;
  localparam logic [TIMER_BITS-1:0]  RST_IDLE_TIMEOUT   = TIMER_BITS'(3000);
  localparam logic [TIMER_BITS-1:0]  RST_TURN_DURATION  = TIMER_BITS'(5000);

  // Servo angles.
  localparam logic [7:0] SERVO_UP     = 8'd0;
  localparam logic [7:0] SERVO_CENTER = 8'd90;
  localparam logic [7:0] SERVO_DOWN   = 8'd180;

  // Command characters (upper case after folding).
  localparam logic [7:0] CH_F      = 8'h46;
  localparam logic [7:0] CH_B      = 8'h42;
  localparam logic [7:0] CH_L      = 8'h4C;
  localparam logic [7:0] CH_R      = 8'h52;
  localparam logic [7:0] CH_S      = 8'h53;
  localparam logic [7:0] CH_A      = 8'h41;
  localparam logic [7:0] CH_M      = 8'h4D;
  localparam logic [7:0] CH_U      = 8'h55;
  localparam logic [7:0] CH_D      = 8'h44;
  localparam logic [7:0] CH_C      = 8'h43;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_LOW_A  = 8'h61;
  localparam logic [7:0] CH_LOW_Z  = 8'h7A;
  localparam logic [7:0] CASE_DIFF = 8'h20;

  // Input word: a tick with samples or a command byte.
  typedef struct packed {
    logic                   command;
    logic [7:0]             byte_value;
    logic [SAMPLE_BITS-1:0] sample_far_right;
    logic [SAMPLE_BITS-1:0] sample_right;
    logic [SAMPLE_BITS-1:0] sample_center;
    logic [SAMPLE_BITS-1:0] sample_left;
    logic [SAMPLE_BITS-1:0] sample_far_left;
  } in_word_t;

  // Result word.
  typedef struct packed {
    logic [1:0] left_direction;
    logic [1:0] right_direction;
    logic [7:0] left_duty;
    logic [7:0] right_duty;
    logic [7:0] servo_angle;
    logic       auto_active;
    logic       turn_active;
    logic [4:0] line_pattern;
  } out_word_t;

endpackage

`default_nettype wire

>>> rtl/core/line_follower_drive_controller_unit.sv
`default_nettype none

// A word accepted at one clock edge is latched in the input register, processed and
// written into the result register at the first later edge at which that register is free.
// Throughput: one word per cycle while out_stall is low; the input register and result
// register form a two-entry pipeline, so a new word is taken while a finished result waits.
// Reset (rst_n low, synchronous): manual mode, motors stopped, servo at 90 degrees,
// configuration registers at their defaults, both pipeline stages empty.
module line_follower_drive_controller_unit (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire lfdc_pkg::in_word_t                    in_word,
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output lfdc_pkg::out_word_t                        out_word,
  input  wire logic                                  cfg_we,
  input  wire logic [lfdc_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  wire logic [lfdc_pkg::CFG_DATA_BITS-1:0]    cfg_data
);
  import lfdc_pkg::*;

  // Configuration registers.
  logic [SAMPLE_BITS-1:0] line_threshold_r;
  logic                   invert_sensors_r;
  logic [7:0]             follow_speed_r;
  logic [7:0]             turn_speed_r;
  logic [7:0]             manual_speed_r;
  logic [TIMER_BITS-1:0]  idle_timeout_r;
  logic [TIMER_BITS-1:0]  turn_duration_r;

  // Pipeline registers.
  logic      s1_valid_r;
  in_word_t  s1_word_r;
  logic      out_valid_r;
  out_word_t out_word_r;
  logic      out_load;
  logic      s1_load;

  // Controller state and its next values.
  logic                  auto_r, auto_nxt;
  logic                  turning_r, turning_nxt;
  logic [TIMER_BITS-1:0] turn_rem_r, turn_rem_nxt;
  logic [TIMER_BITS-1:0] idle_r, idle_nxt;
  logic                  armed_r, armed_nxt;
  logic                  last_turn_r, last_turn_nxt;
  logic [1:0]            ldir_r, ldir_nxt;
  logic [1:0]            rdir_r, rdir_nxt;
  logic [7:0]            lduty_r, lduty_nxt;
  logic [7:0]            rduty_r, rduty_nxt;
  logic [7:0]            servo_r, servo_nxt;

  // Combinational helpers.
  logic [4:0]            pattern;
  logic [TIMER_BITS-1:0] idle_inc;
  logic [TIMER_BITS-1:0] rem_dec;
  logic [7:0]            cmd;
  logic [3:0]            digit;
  logic                  adjacent;
  out_word_t             result;

  // Handshake: the result register loads when empty or being drained; the input
  // register moves on whenever its word is processed.
  assign out_load  = !out_valid_r || !out_stall;
  assign in_stall  = s1_valid_r && !out_load;
  assign s1_load   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // Threshold the five samples, with optional inversion.
  always_comb begin
    pattern[0] = (s1_word_r.sample_far_right >= line_threshold_r) ^ invert_sensors_r;
    pattern[1] = (s1_word_r.sample_right     >= line_threshold_r) ^ invert_sensors_r;
    pattern[2] = (s1_word_r.sample_center    >= line_threshold_r) ^ invert_sensors_r;
    pattern[3] = (s1_word_r.sample_left      >= line_threshold_r) ^ invert_sensors_r;
    pattern[4] = (s1_word_r.sample_far_left  >= line_threshold_r) ^ invert_sensors_r;
  end

  // Case-fold the command byte and form the digit angle (d*16 + d*4).
  always_comb begin
    if (s1_word_r.byte_value >= CH_LOW_A && s1_word_r.byte_value <= CH_LOW_Z) begin
      cmd = s1_word_r.byte_value - CASE_DIFF;
    end else begin
      cmd = s1_word_r.byte_value;
    end
    digit = 4'(cmd - CH_ZERO);
  end

  assign idle_inc = (idle_r != {TIMER_BITS{1'b1}}) ? idle_r + 1'b1 : idle_r;
  assign rem_dec  = (turn_rem_r != '0) ? turn_rem_r - 1'b1 : turn_rem_r;
  assign adjacent = (pattern[1:0] == 2'b11) || (pattern[2:1] == 2'b11) ||
                    (pattern[3:2] == 2'b11) || (pattern[4:3] == 2'b11);

  // Next controller state for the word held in the input register.
  always_comb begin
    auto_nxt      = auto_r;
    turning_nxt   = turning_r;
    turn_rem_nxt  = turn_rem_r;
    idle_nxt      = idle_r;
    armed_nxt     = armed_r;
    last_turn_nxt = last_turn_r;
    ldir_nxt      = ldir_r;
    rdir_nxt      = rdir_r;
    lduty_nxt     = lduty_r;
    rduty_nxt     = rduty_r;
    servo_nxt     = servo_r;
    if (s1_word_r.command) begin
      // Command byte; dropped while a timed turn runs.
      if (!turning_r) begin
        idle_nxt      = '0;
        armed_nxt     = 1'b1;
        last_turn_nxt = (cmd == CH_L) || (cmd == CH_R);
        unique case (cmd)
          CH_F: begin
            if (!auto_r) begin
              ldir_nxt  = DIR_FWD;
              rdir_nxt  = DIR_FWD;
              lduty_nxt = manual_speed_r;
              rduty_nxt = manual_speed_r;
            end
          end
          CH_B: begin
            if (!auto_r) begin
              ldir_nxt  = DIR_BACK;
              rdir_nxt  = DIR_BACK;
              lduty_nxt = manual_speed_r;
              rduty_nxt = manual_speed_r;
            end
          end
          CH_L: begin
            if (!auto_r) begin
              ldir_nxt     = DIR_FWD;
              rdir_nxt     = DIR_BACK;
              lduty_nxt    = turn_speed_r;
              rduty_nxt    = turn_speed_r;
              turning_nxt  = 1'b1;
              turn_rem_nxt = turn_duration_r;
            end
          end
          CH_R: begin
            if (!auto_r) begin
              ldir_nxt     = DIR_BACK;
              rdir_nxt     = DIR_FWD;
              lduty_nxt    = turn_speed_r;
              rduty_nxt    = turn_speed_r;
              turning_nxt  = 1'b1;
              turn_rem_nxt = turn_duration_r;
            end
          end
          CH_S: begin
            ldir_nxt  = DIR_STOP;
            rdir_nxt  = DIR_STOP;
            lduty_nxt = '0;
            rduty_nxt = '0;
          end
          CH_A: begin
            auto_nxt = 1'b1;
          end
          CH_M: begin
            auto_nxt  = 1'b0;
            ldir_nxt  = DIR_STOP;
            rdir_nxt  = DIR_STOP;
            lduty_nxt = '0;
            rduty_nxt = '0;
          end
          CH_U: servo_nxt = SERVO_UP;
          CH_D: servo_nxt = SERVO_DOWN;
          CH_C: servo_nxt = SERVO_CENTER;
          default: begin
            if (cmd >= CH_ZERO && cmd <= CH_NINE) begin
              servo_nxt = {digit, 4'b0000} + {2'b00, digit, 2'b00};
            end
          end
        endcase
      end
    end else begin
      // Tick: count idle time, then run the turn timer, follow or time out.
      idle_nxt = idle_inc;
      if (turning_r) begin
        turn_rem_nxt = rem_dec;
        if (rem_dec == '0) begin
          turning_nxt = 1'b0;
          ldir_nxt    = DIR_STOP;
          rdir_nxt    = DIR_STOP;
          lduty_nxt   = '0;
          rduty_nxt   = '0;
        end
      end else if (auto_r) begin
        priority if (pattern == 5'b00100 || adjacent) begin
          ldir_nxt  = DIR_FWD;
          rdir_nxt  = DIR_FWD;
          lduty_nxt = follow_speed_r;
          rduty_nxt = follow_speed_r;
        end else if (pattern == 5'b00001 || pattern == 5'b00010) begin
          ldir_nxt  = DIR_FWD;
          rdir_nxt  = DIR_BACK;
          lduty_nxt = follow_speed_r;
          rduty_nxt = turn_speed_r;
        end else if (pattern == 5'b01000 || pattern == 5'b10000) begin
          ldir_nxt  = DIR_BACK;
          rdir_nxt  = DIR_FWD;
          lduty_nxt = turn_speed_r;
          rduty_nxt = follow_speed_r;
        end else begin
          ldir_nxt  = DIR_BACK;
          rdir_nxt  = DIR_FWD;
          lduty_nxt = turn_speed_r;
          rduty_nxt = turn_speed_r;
        end
      end else if (idle_inc > idle_timeout_r && armed_r && !last_turn_r) begin
        ldir_nxt  = DIR_STOP;
        rdir_nxt  = DIR_STOP;
        lduty_nxt = '0;
        rduty_nxt = '0;
        armed_nxt = 1'b0;
      end
    end
  end

  // Result word built from the updated state.
  always_comb begin
    result.left_direction  = ldir_nxt;
    result.right_direction = rdir_nxt;
    result.left_duty       = lduty_nxt;
    result.right_duty      = rduty_nxt;
    result.servo_angle     = servo_nxt;
    result.auto_active     = auto_nxt;
    result.turn_active     = turning_nxt;
    result.line_pattern    = s1_word_r.command ? 5'b00000 : pattern;
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_threshold_r <= RST_LINE_THRESHOLD;
      invert_sensors_r <= 1'b0;
      follow_speed_r   <= RST_FOLLOW_SPEED;
      turn_speed_r     <= RST_TURN_SPEED;
      manual_speed_r   <= RST_MANUAL_SPEED;
      idle_timeout_r   <= RST_IDLE_TIMEOUT;
      turn_duration_r  <= RST_TURN_DURATION;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LINE_THRESHOLD: line_threshold_r <= cfg_data[SAMPLE_BITS-1:0];
        CFG_INVERT_SENSORS: invert_sensors_r <= cfg_data[0];
        CFG_FOLLOW_SPEED:   follow_speed_r   <= cfg_data[7:0];
        CFG_TURN_SPEED:     turn_speed_r     <= cfg_data[7:0];
        CFG_MANUAL_SPEED:   manual_speed_r   <= cfg_data[7:0];
        CFG_IDLE_TIMEOUT:   idle_timeout_r   <= cfg_data[TIMER_BITS-1:0];
        CFG_TURN_DURATION:  turn_duration_r  <= cfg_data[TIMER_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline valid flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_valid_r <= 1'b1;
      end else if (out_load) begin
        s1_valid_r <= 1'b0;
      end
      if (out_load) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  // Pipeline payload.
  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_word_r <= in_word;
    end
    if (out_load && s1_valid_r) begin
      out_word_r <= result;
    end
  end

  // Controller state advances when a word leaves the input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      auto_r      <= 1'b0;
      turning_r   <= 1'b0;
      turn_rem_r  <= '0;
      idle_r      <= '0;
      armed_r     <= 1'b1;
      last_turn_r <= 1'b0;
      ldir_r      <= DIR_STOP;
      rdir_r      <= DIR_STOP;
      lduty_r     <= '0;
      rduty_r     <= '0;
      servo_r     <= SERVO_CENTER;
    end else if (out_load && s1_valid_r) begin
      auto_r      <= auto_nxt;
      turning_r   <= turning_nxt;
      turn_rem_r  <= turn_rem_nxt;
      idle_r      <= idle_nxt;
      armed_r     <= armed_nxt;
      last_turn_r <= last_turn_nxt;
      ldir_r      <= ldir_nxt;
      rdir_r      <= rdir_nxt;
      lduty_r     <= lduty_nxt;
      rduty_r     <= rduty_nxt;
      servo_r     <= servo_nxt;
    end
  end

endmodule

`default_nettype wire

>>> bench/tb_line_follower_drive_controller_unit.sv
module tb_line_follower_drive_controller_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import lfdc_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_word_t in_word = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_word_t out_word;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  line_follower_drive_controller_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Words waiting to be sent and drive results waiting to be seen.
  in_word_t pend_words[$];
  out_word_t drive_expected[$];
  int fail_count = 0;

  // Handshake bookkeeping shared by the clocked blocks.
  logic in_taken = 1'b0;
  logic out_taken = 1'b0;
  int send_gap = 0;
  int recv_wait = 0;
  logic no_idle = 1'b0;

  // Shadow of the configuration registers.
  logic [SAMPLE_BITS-1:0] c_thr;
  logic c_inv;
  logic [7:0] c_follow;
  logic [7:0] c_turn;
  logic [7:0] c_manual;
  logic [TIMER_BITS-1:0] c_idle_limit;
  logic [TIMER_BITS-1:0] c_turn_len;

  // Shadow of the controller state.
  logic p_auto;
  logic p_turning;
  logic [TIMER_BITS-1:0] p_turn_left;
  logic [TIMER_BITS-1:0] p_idle;
  logic p_armed;
  logic p_last_turn;
  logic [1:0] p_ldir;
  logic [1:0] p_rdir;
  logic [7:0] p_lduty;
  logic [7:0] p_rduty;
  logic [7:0] p_servo;

  initial begin
    forever #6 clk = ~clk;
  end

  // Give up after a time far beyond the slowest correct run.
  initial begin
    #3_000_000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic void set_motors(logic [1:0] ld, logic [1:0] rd, logic [7:0] lp,
                                     logic [7:0] rp);
    p_ldir = ld;
    p_rdir = rd;
    p_lduty = lp;
    p_rduty = rp;
  endfunction

  function automatic logic sense_line(logic [SAMPLE_BITS-1:0] s);
    return (s >= c_thr) ^ c_inv;
  endfunction

  // Advance the shadow controller by one word and return the drive it produces.
  function automatic out_word_t drive_response(in_word_t w);
    out_word_t r;
    logic [7:0] ch;
    logic [4:0] seen;
    logic adj;
    seen = '0;
    if (w.command) begin
      // Bytes that arrive during a timed turn are dropped entirely.
      if (!p_turning) begin
        ch = w.byte_value;
        if (ch >= CH_LOW_A && ch <= CH_LOW_Z) ch = ch - CASE_DIFF;
        p_idle = '0;
        p_armed = 1'b1;
        p_last_turn = (ch == CH_L) || (ch == CH_R);
        case (ch)
          CH_F: if (!p_auto) set_motors(DIR_FWD, DIR_FWD, c_manual, c_manual);
          CH_B: if (!p_auto) set_motors(DIR_BACK, DIR_BACK, c_manual, c_manual);
          CH_L: if (!p_auto) begin
            set_motors(DIR_FWD, DIR_BACK, c_turn, c_turn);
            p_turning = 1'b1;
            p_turn_left = c_turn_len;
          end
          CH_R: if (!p_auto) begin
            set_motors(DIR_BACK, DIR_FWD, c_turn, c_turn);
            p_turning = 1'b1;
            p_turn_left = c_turn_len;
          end
          CH_S: set_motors(DIR_STOP, DIR_STOP, 8'd0, 8'd0);
          CH_A: p_auto = 1'b1;
          CH_M: begin
            p_auto = 1'b0;
            set_motors(DIR_STOP, DIR_STOP, 8'd0, 8'd0);
          end
          CH_U: p_servo = SERVO_UP;
          CH_D: p_servo = SERVO_DOWN;
          CH_C: p_servo = SERVO_CENTER;
          default: begin
            if (ch >= CH_ZERO && ch <= CH_NINE) p_servo = (ch - CH_ZERO) * 8'd20;
          end
        endcase
      end
    end else begin
      seen = {sense_line(w.sample_far_left), sense_line(w.sample_left),
              sense_line(w.sample_center), sense_line(w.sample_right),
              sense_line(w.sample_far_right)};
      if (p_idle != '1) p_idle = p_idle + 1'b1;
      if (p_turning) begin
        // A running turn only counts down; no following and no timeout.
        if (p_turn_left != '0) p_turn_left = p_turn_left - 1'b1;
        if (p_turn_left == '0) begin
          p_turning = 1'b0;
          set_motors(DIR_STOP, DIR_STOP, 8'd0, 8'd0);
        end
      end else if (p_auto) begin
        adj = (seen[1:0] == 2'b11) || (seen[2:1] == 2'b11) ||
              (seen[3:2] == 2'b11) || (seen[4:3] == 2'b11);
        if (seen == 5'b00100 || adj) set_motors(DIR_FWD, DIR_FWD, c_follow, c_follow);
        else if (seen == 5'b00001 || seen == 5'b00010)
          set_motors(DIR_FWD, DIR_BACK, c_follow, c_turn);
        else if (seen == 5'b01000 || seen == 5'b10000)
          set_motors(DIR_BACK, DIR_FWD, c_turn, c_follow);
        else set_motors(DIR_BACK, DIR_FWD, c_turn, c_turn);
      end else if (p_idle > c_idle_limit && p_armed && !p_last_turn) begin
        set_motors(DIR_STOP, DIR_STOP, 8'd0, 8'd0);
        p_armed = 1'b0;
      end
    end
    r.left_direction = p_ldir;
    r.right_direction = p_rdir;
    r.left_duty = p_lduty;
    r.right_duty = p_rduty;
    r.servo_angle = p_servo;
    r.auto_active = p_auto;
    r.turn_active = p_turning;
    r.line_pattern = seen;
    return r;
  endfunction

  function automatic int draw_gap();
    return no_idle ? 0 : $urandom_range(0, 7);
  endfunction

  function automatic in_word_t tick_word(logic [SAMPLE_BITS-1:0] fr, logic [SAMPLE_BITS-1:0] rt,
                                         logic [SAMPLE_BITS-1:0] ce, logic [SAMPLE_BITS-1:0] lt,
                                         logic [SAMPLE_BITS-1:0] fl);
    in_word_t w;
    w.command = 1'b0;
    w.byte_value = 8'($urandom_range(0, 255));
    w.sample_far_right = fr;
    w.sample_right = rt;
    w.sample_center = ce;
    w.sample_left = lt;
    w.sample_far_left = fl;
    return w;
  endfunction

  function automatic in_word_t byte_word(logic [7:0] ch);
    in_word_t w;
    w = tick_word(SAMPLE_BITS'($urandom_range(0, 4095)), SAMPLE_BITS'($urandom_range(0, 4095)),
                  SAMPLE_BITS'($urandom_range(0, 4095)), SAMPLE_BITS'($urandom_range(0, 4095)),
                  SAMPLE_BITS'($urandom_range(0, 4095)));
    w.command = 1'b1;
    w.byte_value = ch;
    return w;
  endfunction

  // Pick a sample on the wanted side of the threshold, often right at the boundary.
  function automatic logic [SAMPLE_BITS-1:0] pick_sample(logic want_hit);
    logic [SAMPLE_BITS-1:0] v;
    if ($urandom_range(0, 9) == 0) v = SAMPLE_BITS'($urandom_range(0, 4095));
    else if (want_hit)
      v = ($urandom_range(0, 3) == 0) ? c_thr : SAMPLE_BITS'($urandom_range(c_thr, 4095));
    else if (c_thr == '0) v = SAMPLE_BITS'($urandom_range(0, 4095));
    else
      v = ($urandom_range(0, 3) == 0) ? c_thr - 1'b1 :
          SAMPLE_BITS'($urandom_range(0, c_thr - 1'b1));
    return v;
  endfunction

  // Mostly ticks with meaningful line shapes and known commands, some noise bytes.
  function automatic in_word_t random_word();
    in_word_t w;
    logic [4:0] shape;
    logic [4:0] raw;
    logic [7:0] ch;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      case ($urandom_range(0, 13))
        0: shape = 5'b00100;
        1: shape = 5'b00011;
        2: shape = 5'b00110;
        3: shape = 5'b01100;
        4: shape = 5'b11000;
        5: shape = 5'b00001;
        6: shape = 5'b00010;
        7: shape = 5'b01000;
        8: shape = 5'b10000;
        9: shape = 5'b00000;
        10: shape = 5'b11111;
        default: shape = 5'($urandom_range(0, 31));
      endcase
      raw = shape ^ {5{c_inv}};
      w = tick_word(pick_sample(raw[0]), pick_sample(raw[1]), pick_sample(raw[2]),
                    pick_sample(raw[3]), pick_sample(raw[4]));
    end else if (r < 95) begin
      case ($urandom_range(0, 12))
        0: ch = CH_F;
        1: ch = CH_B;
        2: ch = CH_L;
        3: ch = CH_R;
        4, 12: ch = CH_S;
        5: ch = CH_A;
        6, 7: ch = CH_M;
        8: ch = CH_U;
        9: ch = CH_D;
        10: ch = CH_C;
        default: ch = CH_ZERO + 8'($urandom_range(0, 9));
      endcase
      if (ch >= CH_A && $urandom_range(0, 1) == 1) ch = ch | CASE_DIFF;
      w = byte_word(ch);
    end else begin
      w = byte_word(8'($urandom_range(0, 255)));
    end
    return w;
  endfunction

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_LINE_THRESHOLD: c_thr = val[SAMPLE_BITS-1:0];
      CFG_INVERT_SENSORS: c_inv = val[0];
      CFG_FOLLOW_SPEED: c_follow = val[7:0];
      CFG_TURN_SPEED: c_turn = val[7:0];
      CFG_MANUAL_SPEED: c_manual = val[7:0];
      CFG_IDLE_TIMEOUT: c_idle_limit = val[TIMER_BITS-1:0];
      CFG_TURN_DURATION: c_turn_len = val[TIMER_BITS-1:0];
      default: ;
    endcase
  endtask

  task automatic load_config(logic [SAMPLE_BITS-1:0] thr, logic inv, logic [7:0] fol,
                             logic [7:0] trn, logic [7:0] man, logic [TIMER_BITS-1:0] idle,
                             logic [TIMER_BITS-1:0] dur);
    write_reg(CFG_LINE_THRESHOLD, CFG_DATA_BITS'(thr));
    write_reg(CFG_INVERT_SENSORS, CFG_DATA_BITS'(inv));
    write_reg(CFG_FOLLOW_SPEED, CFG_DATA_BITS'(fol));
    write_reg(CFG_TURN_SPEED, CFG_DATA_BITS'(trn));
    write_reg(CFG_MANUAL_SPEED, CFG_DATA_BITS'(man));
    write_reg(CFG_IDLE_TIMEOUT, CFG_DATA_BITS'(idle));
    write_reg(CFG_TURN_DURATION, CFG_DATA_BITS'(dur));
    @(negedge clk);
    cfg_we <= 1'b0;
    #1;
  endtask

  // Hold until every word is sent and every result has come back.
  task automatic wait_drained();
    do begin
      @(negedge clk);
      #1;
    end while (pend_words.size() != 0 || in_valid || in_taken || drive_expected.size() != 0);
  endtask

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  // Note each word the controller takes at the rising edge.
  always @(posedge clk) begin
    in_taken <= rst_n && in_valid && !in_stall;
  end

  // Driver: predict the taken word, then present the next one after a random gap.
  always @(negedge clk) begin
    in_word_t nxt_word;
    logic nxt_valid;
    nxt_word = in_word;
    nxt_valid = in_valid;
    if (rst_n) begin
      if (in_taken) begin
        drive_expected.push_back(drive_response(in_word));
        nxt_valid = 1'b0;
        send_gap = draw_gap();
      end
      if (!nxt_valid) begin
        if (send_gap > 0) send_gap--;
        else if (pend_words.size() > 0) begin
          nxt_word = pend_words.pop_front();
          nxt_valid = 1'b1;
        end
      end
    end
    in_valid <= nxt_valid;
    in_word <= nxt_word;
  end

  // Monitor: compare every result word with the oldest prediction.
  always @(posedge clk) begin
    out_word_t want;
    logic took;
    took = rst_n && (out_valid === 1'b1) && !out_stall;
    if (took) begin
      if (drive_expected.size() == 0) begin
        $display("%0t ns: unexpected result word, expected none, actual %h", $time, out_word);
        fail_count++;
      end else begin
        want = drive_expected.pop_front();
        check_field("left_direction", want.left_direction, out_word.left_direction);
        check_field("right_direction", want.right_direction, out_word.right_direction);
        check_field("left_duty", want.left_duty, out_word.left_duty);
        check_field("right_duty", want.right_duty, out_word.right_duty);
        check_field("servo_angle", want.servo_angle, out_word.servo_angle);
        check_field("auto_active", want.auto_active, out_word.auto_active);
        check_field("turn_active", want.turn_active, out_word.turn_active);
        check_field("line_pattern", want.line_pattern, out_word.line_pattern);
      end
    end
    out_taken <= took;
  end

  // Receiver back-pressure: stall a random number of cycles after each result.
  always @(negedge clk) begin
    logic nxt_stall;
    nxt_stall = 1'b0;
    if (rst_n) begin
      if (out_taken) recv_wait = draw_gap();
      if (recv_wait > 0) begin
        nxt_stall = 1'b1;
        recv_wait--;
      end
    end
    out_stall <= nxt_stall;
  end

  // Stimulus: reset, directed checks, then randomized phases under varied settings.
  initial begin
    logic [SAMPLE_BITS-1:0] thr_v;
    logic [7:0] fol_v;
    logic [7:0] trn_v;
    logic [7:0] man_v;
    logic [TIMER_BITS-1:0] idle_v;
    logic [TIMER_BITS-1:0] dur_v;

    c_thr = RST_LINE_THRESHOLD;
    c_inv = 1'b0;
    c_follow = RST_FOLLOW_SPEED;
    c_turn = RST_TURN_SPEED;
    c_manual = RST_MANUAL_SPEED;
    c_idle_limit = RST_IDLE_TIMEOUT;
    c_turn_len = RST_TURN_DURATION;
    p_auto = 1'b0;
    p_turning = 1'b0;
    p_turn_left = '0;
    p_idle = '0;
    p_armed = 1'b1;
    p_last_turn = 1'b0;
    set_motors(DIR_STOP, DIR_STOP, 8'd0, 8'd0);
    p_servo = SERVO_CENTER;

    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    #1;

    // Reset settings: a manual tick, a move, case folding, a servo digit, unknown bytes.
    pend_words.push_back(tick_word(12'd0, 12'd0, 12'd4095, 12'd0, 12'd0));
    pend_words.push_back(byte_word(CH_F));
    pend_words.push_back(byte_word(CH_U | CASE_DIFF));
    pend_words.push_back(byte_word(CH_NINE));
    pend_words.push_back(byte_word(8'hFF));
    pend_words.push_back(byte_word("H"));
    wait_drained();

    // Short timers: idle timeout, timed turns, dropped bytes, then auto following.
    load_config(RST_LINE_THRESHOLD, 1'b0, RST_FOLLOW_SPEED, RST_TURN_SPEED,
                RST_MANUAL_SPEED, 16'd2, 16'd3);
    pend_words.push_back(byte_word(CH_F));
    repeat (3) pend_words.push_back(tick_word(12'd2000, 12'd1999, 12'd2000, 12'd1999, 12'd2000));
    pend_words.push_back(byte_word(CH_L));
    pend_words.push_back(byte_word(CH_F));
    repeat (3) pend_words.push_back(tick_word(12'd0, 12'd0, 12'd0, 12'd0, 12'd0));
    pend_words.push_back(byte_word(CH_R | CASE_DIFF));
    repeat (3) pend_words.push_back(tick_word(12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095));
    pend_words.push_back(byte_word(CH_B));
    pend_words.push_back(byte_word(CH_S));
    pend_words.push_back(byte_word(CH_A | CASE_DIFF));
    pend_words.push_back(tick_word(12'd0, 12'd0, 12'd4095, 12'd0, 12'd0));
    pend_words.push_back(tick_word(12'd4095, 12'd4095, 12'd0, 12'd0, 12'd0));
    pend_words.push_back(tick_word(12'd4095, 12'd0, 12'd0, 12'd0, 12'd0));
    pend_words.push_back(tick_word(12'd0, 12'd0, 12'd0, 12'd4095, 12'd0));
    pend_words.push_back(tick_word(12'd0, 12'd0, 12'd0, 12'd0, 12'd0));
    pend_words.push_back(byte_word(CH_F));
    pend_words.push_back(byte_word(CH_L));
    pend_words.push_back(byte_word(CH_M));
    wait_drained();

    // Random phases; each one ends with the sender paused until all results are in.
    for (int ph = 0; ph < 8; ph++) begin
      thr_v = (ph == 0) ? 12'd0 : (ph == 1) ? 12'd4095 : 12'($urandom_range(1, 4094));
      if (ph == 2) begin
        fol_v = 8'd0;
        trn_v = 8'd0;
        man_v = 8'd0;
      end else if (ph == 3) begin
        fol_v = 8'd255;
        trn_v = 8'd255;
        man_v = 8'd255;
      end else begin
        fol_v = 8'($urandom_range(0, 255));
        trn_v = 8'($urandom_range(0, 255));
        man_v = 8'($urandom_range(0, 255));
      end
      idle_v = (ph == 4) ? 16'hFFFF : (ph == 5) ? 16'd0 : 16'($urandom_range(1, 30));
      // The longest turn comes last since it never ends within a phase.
      dur_v = (ph == 7) ? 16'hFFFF : (ph == 5) ? 16'd0 : (ph == 6) ? 16'd1 :
              16'($urandom_range(2, 20));
      load_config(thr_v, 1'(ph % 2), fol_v, trn_v, man_v, idle_v, dur_v);
      no_idle = (ph % 3 == 1);
      for (int i = 0; i < 110; i++) pend_words.push_back(random_word());
      wait_drained();
    end

    repeat (20) @(posedge clk);
    if (fail_count == 0 && drive_expected.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
